// ----- src/exl_pkg.sv -----
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types, token codes and the byte classifier of the expression lexer.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int POSITION_BITS = 16;
    localparam int VALUE_BITS    = 32;
    localparam int COUNT_BITS    = 16;
    localparam int KIND_BITS     = 4;
    localparam int LIMIT_BITS    = 8;
    localparam int WIDE_BITS     = VALUE_BITS + 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd255;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_IDENT  = 4'd0;
    localparam logic [KIND_BITS-1:0] K_NUMBER = 4'd1;
    localparam logic [KIND_BITS-1:0] K_PLUS   = 4'd2;
    localparam logic [KIND_BITS-1:0] K_MINUS  = 4'd3;
    localparam logic [KIND_BITS-1:0] K_STAR   = 4'd4;
    localparam logic [KIND_BITS-1:0] K_OPEN   = 4'd5;
    localparam logic [KIND_BITS-1:0] K_CLOSE  = 4'd6;
    localparam logic [KIND_BITS-1:0] K_END    = 4'd7;
    localparam logic [KIND_BITS-1:0] K_ERROR  = 4'd8;
    // byte classes beyond the token kinds
    localparam logic [KIND_BITS-1:0] C_WS     = 4'd9;
    localparam logic [KIND_BITS-1:0] C_DIGIT  = 4'd10;
    localparam logic [KIND_BITS-1:0] C_ALPHA  = 4'd11;

    // scan modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_NUM   = 2'd2;
    localparam logic [1:0] MODE_HALT  = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0]     kind;
        logic [POSITION_BITS-1:0] start;
        logic [COUNT_BITS-1:0]    length;
        logic [VALUE_BITS-1:0]    value;
        logic                     overflow;
        logic                     last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_push;

    function automatic logic [KIND_BITS-1:0] classify(input logic [7:0] c);
        logic [KIND_BITS-1:0] cls;
        if (c == 8'h00) begin
            cls = K_END;
        end else if (c < 8'h21) begin
            cls = C_WS;
        end else if (c >= 8'h30 && c < 8'h3a) begin
            cls = C_DIGIT;
        end else if ((c >= 8'h61 && c < 8'h7b) || (c >= 8'h41 && c < 8'h5b)
                     || c == 8'h5f) begin
            cls = C_ALPHA;
        end else begin
            unique case (c)
                8'h2b:   cls = K_PLUS;
                8'h2d:   cls = K_MINUS;
                8'h2a:   cls = K_STAR;
                8'h28:   cls = K_OPEN;
                8'h29:   cls = K_CLOSE;
                default: cls = K_ERROR;
            endcase
        end
        return cls;
    endfunction

endpackage

// ----- src/exl_stream_if.sv -----
// ----------------------------------------------------------------------------
// exl_byte_if / exl_token_if
// Valid/ready channels for source bytes and lexer tokens.
// ----------------------------------------------------------------------------
interface exl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       new_formula;

    modport source (output valid, char_byte, new_formula, input ready);
    modport sink   (input valid, char_byte, new_formula, output ready);
endinterface

interface exl_token_if import exl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_BITS-1:0]     token_kind;
    logic [POSITION_BITS-1:0] start_position;
    logic [COUNT_BITS-1:0]    token_length;
    logic [VALUE_BITS-1:0]    number_value;
    logic                     number_overflow;
    logic                     last;

    modport source (output valid, token_kind, start_position, token_length,
                    number_value, number_overflow, last, input ready);
    modport sink   (input valid, token_kind, start_position, token_length,
                    number_value, number_overflow, last, output ready);
endinterface

// ----- src/exl_scan.sv -----
// ----------------------------------------------------------------------------
// exl_scan
// Scanner state and per-byte token logic; yields up to two tokens per word.
// ----------------------------------------------------------------------------
module exl_scan import exl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    input  logic                  i_fire,
    input  logic [7:0]            i_char_byte,
    input  logic                  i_new_formula,
    output t_push                 o_push
);

    logic [LIMIT_BITS-1:0]    r_limit;
    logic [1:0]               r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [COUNT_BITS-1:0]    r_count, n_count;
    logic [VALUE_BITS-1:0]    r_acc,   n_acc;
    logic                     r_ovf,   n_ovf;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;

    logic [1:0]               cur_mode;
    logic [POSITION_BITS-1:0] cur_start;
    logic [COUNT_BITS-1:0]    cur_count;
    logic [VALUE_BITS-1:0]    cur_acc;
    logic                     cur_ovf;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [KIND_BITS-1:0]     cls;
    logic [COUNT_BITS-1:0]    limit;
    logic [COUNT_BITS-1:0]    count_inc;
    logic [3:0]               digit;
    logic [WIDE_BITS-1:0]     wide;
    logic                     consumed;
    logic                     emit_a, emit_b;
    t_token                   tok_a, tok_b;

    always_comb begin
        cur_mode  = i_new_formula ? MODE_IDLE : r_mode;
        cur_start = i_new_formula ? '0 : r_start;
        cur_count = i_new_formula ? '0 : r_count;
        cur_acc   = i_new_formula ? '0 : r_acc;
        cur_ovf   = i_new_formula ? 1'b0 : r_ovf;
        cur_pos   = i_new_formula ? '0 : r_pos;

        cls   = classify(i_char_byte);
        limit = (r_limit == '0) ? COUNT_BITS'(1) : COUNT_BITS'(r_limit);
        count_inc = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
        digit = 4'(i_char_byte - 8'h30);
        wide  = (WIDE_BITS'(cur_acc) << 3) + (WIDE_BITS'(cur_acc) << 1)
              + WIDE_BITS'(digit);

        n_mode  = cur_mode;
        n_start = cur_start;
        n_count = cur_count;
        n_acc   = cur_acc;
        n_ovf   = cur_ovf;
        n_pos   = cur_pos + 1'b1;
        consumed = 1'b0;
        emit_a = 1'b0;
        emit_b = 1'b0;
        tok_a  = '0;
        tok_b  = '0;

        if (cur_mode == MODE_HALT) begin
            consumed = 1'b1;
            n_pos    = cur_pos;
        end else if (cur_mode == MODE_IDENT) begin
            if (cls == C_ALPHA || cls == C_DIGIT) begin
                n_count  = count_inc;
                consumed = 1'b1;
                if (count_inc >= limit) begin
                    emit_a       = 1'b1;
                    tok_a.kind   = K_IDENT;
                    tok_a.start  = cur_start;
                    tok_a.length = count_inc;
                    n_mode       = MODE_IDLE;
                end
            end else begin
                emit_a       = 1'b1;
                tok_a.kind   = K_IDENT;
                tok_a.start  = cur_start;
                tok_a.length = cur_count;
                n_mode       = MODE_IDLE;
            end
        end else if (cur_mode == MODE_NUM) begin
            if (cls == C_DIGIT) begin
                n_acc    = wide[VALUE_BITS-1:0];
                n_ovf    = cur_ovf | (wide[WIDE_BITS-1:VALUE_BITS] != '0);
                n_count  = count_inc;
                consumed = 1'b1;
            end else begin
                emit_a         = 1'b1;
                tok_a.kind     = K_NUMBER;
                tok_a.start    = cur_start;
                tok_a.length   = cur_count;
                tok_a.value    = cur_acc;
                tok_a.overflow = cur_ovf;
                n_mode         = MODE_IDLE;
            end
        end

        if (!consumed) begin
            tok_b.start  = cur_pos;
            tok_b.length = COUNT_BITS'(1);
            tok_b.kind   = cls;
            priority if (cls == C_WS) begin
                n_mode = (n_mode == MODE_HALT) ? MODE_HALT : MODE_IDLE;
            end else if (cls == C_ALPHA) begin
                n_start = cur_pos;
                n_count = COUNT_BITS'(1);
                n_mode  = MODE_IDENT;
                if (limit == COUNT_BITS'(1)) begin
                    emit_b     = 1'b1;
                    tok_b.kind = K_IDENT;
                    n_mode     = MODE_IDLE;
                end
            end else if (cls == C_DIGIT) begin
                n_start = cur_pos;
                n_count = COUNT_BITS'(1);
                n_acc   = VALUE_BITS'(digit);
                n_ovf   = 1'b0;
                n_mode  = MODE_NUM;
            end else if (cls == K_END) begin
                emit_b       = 1'b1;
                tok_b.length = '0;
                n_mode       = MODE_HALT;
            end else if (cls == K_ERROR) begin
                emit_b = 1'b1;
                n_mode = MODE_HALT;
            end else begin
                emit_b = 1'b1;
            end
        end

        tok_a.last = !emit_b;
        tok_b.last = 1'b1;
        o_push.count  = i_fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
        o_push.first  = emit_a ? tok_a : tok_b;
        o_push.second = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_count <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_count <= n_count;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_pos   <= n_pos;
            end
        end
    end

endmodule

// ----- src/exl_outq.sv -----
// ----------------------------------------------------------------------------
// exl_outq
// Four-entry token queue; takes up to two tokens a cycle, delivers one.
// ----------------------------------------------------------------------------
module exl_outq import exl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token
);

    t_token     r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    always_comb begin
        pop     = (r_count != 3'd0) && i_ready;
        n_wr    = r_wr + i_push.count;
        n_rd    = r_rd + 2'(pop);
        n_count = r_count + 3'(i_push.count) - 3'(pop);
        o_room  = (r_count <= 3'd2);
        o_valid = (r_count != 3'd0);
        o_token = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- src/arithmetic_expression_lexer_top.sv -----
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer_top
// Expression lexer: one source byte per word in, tokens out.
// A token enters the token queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// two tokens puts both into the four-entry token queue, which delivers one at a time.
// Reset: synchronous, active low; name limit 255, scanner idle, queue empty.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer_top import exl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    exl_byte_if.sink              i_in,
    exl_token_if.source           o_out
);

    t_push  push;
    t_token head;
    logic   room;

    assign i_in.ready = room;

    exl_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_fire        (i_in.valid && room),
        .i_char_byte   (i_in.char_byte),
        .i_new_formula (i_in.new_formula),
        .o_push        (push)
    );

    exl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_token (head)
    );

    assign o_out.token_kind      = head.kind;
    assign o_out.start_position  = head.start;
    assign o_out.token_length    = head.length;
    assign o_out.number_value    = head.value;
    assign o_out.number_overflow = head.overflow;
    assign o_out.last            = head.last;

endmodule

// ----- bench/arithmetic_expression_lexer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer_top_tb
// Feeds formula text one byte per word and checks every token against a
// lexer model kept in the bench. The model runs on each accepted byte, and
// the token stream is compared field by field in order. Phases cover several
// name limits, directed corner bytes, random formulas and noise, halted
// bytes, and one long formula with split names and an overflowing number.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer_top_tb;
    import exl_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       nf;
    } src_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LIMIT_BITS-1:0] i_cfg_wdata;

    exl_byte_if  byte_ch ();
    exl_token_if tok_ch ();

    arithmetic_expression_lexer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_ch),
        .o_out       (tok_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    src_word_t text_backlog[$];
    t_token    tokens_due[$];
    logic      formula_head = 1'b0;
    int        words_queued = 0;
    int        mismatches = 0;
    bit        steady = 1'b0;
    int        send_wait = 0;
    int        send_calm = 0;
    int        take_wait = 0;
    int        take_calm = 0;

    // lexer model state
    logic [LIMIT_BITS-1:0]    name_lim  = LIMIT_RESET;
    logic [1:0]               lex_mode  = MODE_IDLE;
    logic [POSITION_BITS-1:0] tok_start = '0;
    logic [COUNT_BITS-1:0]    tok_count = '0;
    logic [VALUE_BITS-1:0]    acc       = '0;
    logic                     ovf_seen  = 1'b0;
    logic [POSITION_BITS-1:0] pos       = '0;

    function automatic logic [KIND_BITS-1:0] byte_class(logic [7:0] ch);
        if (ch == 8'h00) return K_END;
        if (ch < 8'h21) return C_WS;
        if (ch inside {[8'h30:8'h39]}) return C_DIGIT;
        if (ch inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f}) return C_ALPHA;
        case (ch)
            8'h2b:   return K_PLUS;
            8'h2d:   return K_MINUS;
            8'h2a:   return K_STAR;
            8'h28:   return K_OPEN;
            8'h29:   return K_CLOSE;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic void due_token(logic [KIND_BITS-1:0] kind,
                                      logic [POSITION_BITS-1:0] start,
                                      logic [COUNT_BITS-1:0] len,
                                      logic [VALUE_BITS-1:0] value, logic ovf);
        t_token t;
        t.kind     = kind;
        t.start    = start;
        t.length   = len;
        t.value    = value;
        t.overflow = ovf;
        t.last     = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic void lex_byte(logic [7:0] ch, logic nf);
        logic [KIND_BITS-1:0]     cls;
        logic [POSITION_BITS-1:0] p;
        logic [LIMIT_BITS-1:0]    lim;
        logic [63:0]              wide;
        bit                       took;
        int                       n0;
        n0 = tokens_due.size();
        took = 1'b0;
        if (nf) begin
            lex_mode  = MODE_IDLE;
            tok_start = '0;
            tok_count = '0;
            acc       = '0;
            ovf_seen  = 1'b0;
            pos       = '0;
        end
        if (lex_mode == MODE_HALT) return;
        cls = byte_class(ch);
        p   = pos;
        lim = (name_lim == 0) ? 8'd1 : name_lim;
        if (lex_mode == MODE_IDENT) begin
            if (cls == C_ALPHA || cls == C_DIGIT) begin
                if (tok_count != COUNT_MAX) tok_count++;
                if (tok_count >= lim) begin
                    due_token(K_IDENT, tok_start, tok_count, '0, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                took = 1'b1;
            end else begin
                due_token(K_IDENT, tok_start, tok_count, '0, 1'b0);
                lex_mode = MODE_IDLE;
            end
        end else if (lex_mode == MODE_NUM) begin
            if (cls == C_DIGIT) begin
                wide = {32'd0, acc} * 64'd10 + 64'(ch - 8'h30);
                if (wide[63:32] != 0) ovf_seen = 1'b1;
                acc = wide[31:0];
                if (tok_count != COUNT_MAX) tok_count++;
                took = 1'b1;
            end else begin
                due_token(K_NUMBER, tok_start, tok_count, acc, ovf_seen);
                lex_mode = MODE_IDLE;
            end
        end
        if (!took) begin
            case (cls)
                C_WS: ;
                C_ALPHA: begin
                    tok_start = p;
                    tok_count = 16'd1;
                    lex_mode  = MODE_IDENT;
                    if (tok_count >= lim) begin
                        due_token(K_IDENT, tok_start, tok_count, '0, 1'b0);
                        lex_mode = MODE_IDLE;
                    end
                end
                C_DIGIT: begin
                    tok_start = p;
                    tok_count = 16'd1;
                    acc       = VALUE_BITS'(ch - 8'h30);
                    ovf_seen  = 1'b0;
                    lex_mode  = MODE_NUM;
                end
                K_END: begin
                    due_token(K_END, p, 16'd0, '0, 1'b0);
                    lex_mode = MODE_HALT;
                end
                K_ERROR: begin
                    due_token(K_ERROR, p, 16'd1, '0, 1'b0);
                    lex_mode = MODE_HALT;
                end
                default: due_token(cls, p, 16'd1, '0, 1'b0);
            endcase
        end
        pos = p + 1'b1;
        if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
        return $urandom_range(0, 8);
    endfunction

    // byte driver
    always @(posedge i_clk) begin : drive_bytes
        src_word_t w;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                lex_byte(byte_ch.char_byte, byte_ch.new_formula);
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (send_wait == 0 && text_backlog.size() != 0) begin
                    w = text_backlog.pop_front();
                    byte_ch.valid       <= 1'b1;
                    byte_ch.char_byte   <= w.ch;
                    byte_ch.new_formula <= w.nf;
                    send_wait <= steady ? 0 : draw_wait(send_calm);
                end else begin
                    byte_ch.valid <= 1'b0;
                    if (send_wait != 0) send_wait <= send_wait - 1;
                end
            end
        end
    end

    // token monitor
    always @(posedge i_clk) begin : watch_tokens
        t_token want;
        if (!i_rst_n) begin
            tok_ch.ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (tok_ch.valid && tok_ch.ready) begin
                if (tokens_due.size() == 0) begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           tok_ch.token_kind, tok_ch.start_position, tok_ch.token_length);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    if (tok_ch.token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind,
                               tok_ch.token_kind);
                        mismatches++;
                    end
                    if (tok_ch.start_position !== want.start) begin
                        $error("start_position: expected %0d, got %0d", want.start,
                               tok_ch.start_position);
                        mismatches++;
                    end
                    if (tok_ch.token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d", want.length,
                               tok_ch.token_length);
                        mismatches++;
                    end
                    if (tok_ch.number_value !== want.value) begin
                        $error("number_value: expected %0d, got %0d", want.value,
                               tok_ch.number_value);
                        mismatches++;
                    end
                    if (tok_ch.number_overflow !== want.overflow) begin
                        $error("number_overflow: expected %0b, got %0b", want.overflow,
                               tok_ch.number_overflow);
                        mismatches++;
                    end
                    if (tok_ch.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, tok_ch.last);
                        mismatches++;
                    end
                end
                take_wait = draw_wait(take_calm);
            end else if (!tok_ch.ready && take_wait != 0) begin
                take_wait--;
            end
            tok_ch.ready <= (take_wait == 0);
        end
    end

    function automatic void push_word(logic [7:0] ch, bit counts);
        text_backlog.push_back('{ch: ch, nf: formula_head});
        formula_head = 1'b0;
        if (counts) words_queued++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b1);
    endfunction

    function automatic logic [7:0] name_char(bit first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26) return 8'(8'h41 + r);
        if (r < 52) return 8'(8'h61 + r - 26);
        if (r == 52) return 8'h5f;
        return 8'(8'h30 + r - 53);
    endfunction

    function automatic logic [7:0] error_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255)); while (byte_class(c) != K_ERROR);
        return c;
    endfunction

    task automatic add_formula();
        int len;
        int r;
        formula_head = 1'b1;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 8)) push_word(8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 2)) push_word(8'($urandom_range(1, 32)), 1'b1);
            end
            r = $urandom_range(0, 9);
            if (r < 3) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300)
                                                   : $urandom_range(1, 8);
                push_word(name_char(1'b1), 1'b1);
                repeat (len - 1) push_word(name_char(1'b0), 1'b1);
            end else if (r < 5) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 4);
                repeat (len) push_word(8'(8'h30 + $urandom_range(0, 9)), 1'b1);
            end else begin
                case ($urandom_range(0, 4))
                    0: push_word(8'h2b, 1'b1);
                    1: push_word(8'h2d, 1'b1);
                    2: push_word(8'h2a, 1'b1);
                    3: push_word(8'h28, 1'b1);
                    default: push_word(8'h29, 1'b1);
                endcase
            end
        end
        r = $urandom_range(0, 9);
        if (r < 7) push_word(8'h00, 1'b1);
        else if (r == 7) push_word(error_byte(), 1'b1);
        else return;
        // halted: these bytes must be dropped
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) push_word(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic settle();
        while (text_backlog.size() != 0 || byte_ch.valid || tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_name_limit(logic [LIMIT_BITS-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        name_lim = v;
    endtask

    initial begin
        int limits [7];
        limits = '{1, 0, 2, 0, 7, 255, 254};
        limits[3] = $urandom_range(3, 200);
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.char_byte   = '0;
        byte_ch.new_formula = 1'b0;
        tok_ch.ready        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("_aZz9");
        push_word(8'h01, 1'b1);
        push_text("4294967296");
        push_word(8'h20, 1'b1);
        push_text("+-*()");
        push_word(8'h00, 1'b1);
        push_word(8'hff, 1'b0);
        formula_head = 1'b1;
        push_word(8'hff, 1'b1);
        while (words_queued < 165) add_formula();
        settle();

        foreach (limits[i]) begin
            set_name_limit(8'(limits[i]));
            while (words_queued < 165 * (i + 2)) add_formula();
            settle();
        end

        // one long formula: split name and an overflowing number
        set_name_limit(8'd255);
        steady = 1'b1;
        formula_head = 1'b1;
        repeat (300) push_word(8'h78, 1'b1);
        push_word(8'h20, 1'b1);
        repeat (30) push_word(8'(8'h30 + $urandom_range(0, 9)), 1'b1);
        push_text("+q");
        push_word(8'h00, 1'b1);
        settle();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("arithmetic_expression_lexer_top test passed");
        end else begin
            $display("arithmetic_expression_lexer_top test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("arithmetic_expression_lexer_top test failed");
        $finish;
    end

endmodule
